// ----- sv/rws_pkg.sv -----
// Shared constants, types and codes of the weighted random selector.
package rws_pkg;

  // Table geometry and field widths
  localparam int MAX_ENTRIES = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SUM_W       = WEIGHT_BITS + IDX_W;
  localparam int U_W         = 32;
  localparam int PROD_W      = U_W + SUM_W;
  localparam int WFIELD_W    = 16;

  // Request kinds
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ZERO  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_SCAN,
    S_FIN
  } state_e;

  // Control and operands for the shared multiply/compare unit
  typedef struct packed {
    logic             load;
    logic [U_W-1:0]   uniform;
    logic [SUM_W-1:0] total;
  } cmp_ctrl_t;

endpackage

// ----- sv/rws_if.sv -----
// Request and response channel interfaces of the weighted random selector.
interface rws_req_if;
  import rws_pkg::*;
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [WFIELD_W-1:0] weight;
  logic [U_W-1:0]      uniform;

  modport source (output valid, output req_type, output weight, output uniform, input ready);
  modport sink   (input valid, input req_type, input weight, input uniform, output ready);
endinterface

interface rws_rsp_if;
  import rws_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [1:0]       status;
  logic [CNT_W-1:0] entry_count;

  modport source (output valid, output index, output status, output entry_count, input ready);
  modport sink   (input valid, input index, input status, input entry_count, output ready);
endinterface

// ----- sv/rws_mem.sv -----
// Prefix-sum memory: one write port, one read port with registered data.
module rws_mem (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [rws_pkg::IDX_W-1:0] wr_addr_i,
  input  logic [rws_pkg::SUM_W-1:0] wr_data_i,
  input  logic [rws_pkg::IDX_W-1:0] rd_addr_i,
  output logic [rws_pkg::SUM_W-1:0] rd_data_o
);
  import rws_pkg::*;

  logic [SUM_W-1:0] mem_q [MAX_ENTRIES];

  // Write the new prefix sum
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one entry a cycle
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// ----- sv/rws_cmp.sv -----
// Shared unit: forms u*total once per draw, then tests it against each prefix sum.
module rws_cmp (
  input  logic                      clk_i,
  input  rws_pkg::cmp_ctrl_t        ctrl_i,
  input  logic [rws_pkg::SUM_W-1:0] prefix_i,
  output logic                      hit_o
);
  import rws_pkg::*;

  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] prod_d;
  logic [PROD_W-1:0] bound;

  // Scale the fraction by the total weight
  always_comb begin
    prod_d = PROD_W'(ctrl_i.uniform) * PROD_W'(ctrl_i.total);
  end

  // Hold the product for the whole walk
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_q <= prod_d;
    end
  end

  // Hit when u*total <= prefix * 2^32
  assign bound = {prefix_i, {U_W{1'b0}}};
  assign hit_o = (prod_q <= bound);

endmodule

// ----- sv/rws_ctrl.sv -----
// Sequencer: appends entries, walks the prefix sums on a draw, holds the result.
module rws_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rws_req_if.sink                   req_i,
  rws_rsp_if.source                 rsp_o,
  output logic                      wr_en_o,
  output logic [rws_pkg::IDX_W-1:0] wr_addr_o,
  output logic [rws_pkg::SUM_W-1:0] wr_data_o,
  output logic [rws_pkg::IDX_W-1:0] rd_addr_o,
  output rws_pkg::cmp_ctrl_t        cmp_o,
  input  logic                      hit_i
);
  import rws_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [SUM_W-1:0] total_q, total_d;
  logic [U_W-1:0]   uniform_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  status_e          status_q, status_d;
  logic             out_valid_q;
  logic [IDX_W-1:0] out_index_q;
  status_e          out_status_q;
  logic [CNT_W-1:0] out_count_q;

  logic                 accept;
  logic                 is_full;
  logic                 is_zero;
  logic                 out_free;
  logic                 scan_done;
  logic [WEIGHT_BITS-1:0] w_use;
  logic [IDX_W-1:0]     last_idx;
  logic [CNT_W-1:0]     last_cnt;

  assign accept    = req_i.valid && req_i.ready;
  assign w_use     = req_i.weight[WEIGHT_BITS-1:0];
  assign is_full   = (used_q == CNT_W'(MAX_ENTRIES));
  assign is_zero   = (w_use == '0);
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign last_cnt  = used_q - CNT_W'(1);
  assign last_idx  = last_cnt[IDX_W-1:0];
  assign scan_done = hit_i || (idx_q == last_idx);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.req_type == REQ_DRAW && used_q != '0) begin
            state_d = S_MUL;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_MUL:  state_d = S_SCAN;
      S_SCAN: begin
        if (scan_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control and register updates
  always_comb begin
    req_i.ready  = (state_q == S_IDLE);
    wr_en_o      = 1'b0;
    wr_addr_o    = used_q[IDX_W-1:0];
    wr_data_o    = total_q + SUM_W'(w_use);
    rd_addr_o    = '0;
    cmp_o.load    = (state_q == S_MUL);
    cmp_o.uniform = uniform_q;
    cmp_o.total   = total_q;
    used_d   = used_q;
    total_d  = total_q;
    idx_d    = idx_q;
    status_d = status_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d    = '0;
          status_d = ST_OK;
          if (req_i.req_type == REQ_ADD) begin
            if (is_full) begin
              status_d = ST_FULL;
            end else if (is_zero) begin
              status_d = ST_ZERO;
            end else begin
              wr_en_o = 1'b1;
              idx_d   = used_q[IDX_W-1:0];
              total_d = wr_data_o;
              used_d  = used_q + CNT_W'(1);
            end
          end else if (used_q == '0) begin
            status_d = ST_EMPTY;
          end
        end
      end
      S_MUL: begin
        // Fetch entry zero while the product settles
        rd_addr_o = '0;
        idx_d     = '0;
      end
      S_SCAN: begin
        // Fetch the next entry ahead of its compare
        rd_addr_o = idx_q + IDX_W'(1);
        if (!scan_done) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      total_q <= total_d;
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    status_q <= status_d;
    if (accept) begin
      uniform_q <= req_i.uniform;
    end
    if (state_q == S_FIN && out_free) begin
      out_index_q  <= idx_q;
      out_status_q <= status_q;
      out_count_q  <= used_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.index       = out_index_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_count = out_count_q;

  // Checks
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (used_q != '0 && idx_q <= last_idx))
    else $error("walk outside stored entries");

  a_rsp_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result shown without finishing");

  a_write_only_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |=> (used_q == $past(used_q) + CNT_W'(1)))
    else $error("append did not advance entry count");

endmodule

// ----- sv/weighted_random_selector_top.sv -----
// Top level of the weighted random selector (roulette-wheel selection).
//
// Channels: req_i carries one request per item (req_type, weight, uniform);
// rsp_o returns exactly one result per request (index, status, entry_count).
// Both use valid/ready; an item moves when valid and ready are high together.
// An add stores the running prefix sum of the weight in a 16-entry memory and
// goes through the finish state to the result register. A draw first forms
// uniform*total in the shared multiplier, then walks the prefix sums with one
// comparator at one entry per cycle, stopping at the first hit. Empty-table,
// full-table and zero-weight cases also go straight to the finish state. The
// request side is ready only while the sequencer is idle; the memory read port
// sets the walk rate. Reset clears the entry count, the total and the result
// valid; the memory is not cleared, as only filled entries are ever compared.
// When the receiver stalls the result waits in the output register and the
// next request is still accepted; its result is held until the output register
// is free.
module weighted_random_selector_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  rws_req_if.sink   req_i,
  rws_rsp_if.source rsp_o
);
  import rws_pkg::*;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [SUM_W-1:0] wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [SUM_W-1:0] rd_data;
  cmp_ctrl_t        cmp_ctrl;
  logic             hit;

  rws_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_addr_o (rd_addr),
    .cmp_o     (cmp_ctrl),
    .hit_i     (hit)
  );

  rws_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  rws_cmp u_cmp (
    .clk_i    (clk_i),
    .ctrl_i   (cmp_ctrl),
    .prefix_i (rd_data),
    .hit_o    (hit)
  );

endmodule
